[rtl/swpc_pkg.sv]
// shared widths, register map, payload types and result weights of the water classifier
package swpc_pkg;

  localparam int BAND_W    = 16;
  localparam int SUM_W     = BAND_W + 1;
  localparam int FRAC_BITS = 14;
  localparam int IDX_W     = 16;
  localparam int QUO_W     = IDX_W;
  localparam int NA_W      = SUM_W + FRAC_BITS;
  localparam int TOP_W     = NA_W - QUO_W;
  localparam int HI_W      = (TOP_W > SUM_W) ? TOP_W : SUM_W;
  localparam int REM_W     = SUM_W + 1;
  localparam int CODE_W    = 11;

  localparam int FRONT_STAGES = 2;
  localparam int DIV_STAGES   = QUO_W + 1;
  localparam int BACK_STAGES  = 2;
  localparam int PIPE_LAT     = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_INDEX_GT     = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_INDEX_LT_ONE = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_INDEX_LT_TWO = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_NIR_ONE      = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_NIR_TWO      = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SWIR_ONE     = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_SWIR_TWO     = REG_IDX_W'(6);

  localparam logic [CODE_W-1:0] W_RULE1 = CODE_W'(1);
  localparam logic [CODE_W-1:0] W_RULE2 = CODE_W'(10);
  localparam logic [CODE_W-1:0] W_RULE3 = CODE_W'(100);
  localparam logic [CODE_W-1:0] W_RULE4 = CODE_W'(1000);

  localparam logic [IDX_W-1:0] IDX_MAX = {1'b0, {(IDX_W-1){1'b1}}};
  localparam logic [IDX_W-1:0] IDX_MIN = {1'b1, {(IDX_W-1){1'b0}}};

  typedef struct packed {
    logic signed [BAND_W-1:0] green_band;
    logic signed [BAND_W-1:0] red_band;
    logic signed [BAND_W-1:0] nir_band;
    logic signed [BAND_W-1:0] swir_band;
    logic                     last_pixel;
  } swpc_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] water_code;
    logic              last_pixel_out;
  } swpc_out_t;

  typedef struct packed {
    logic signed [BAND_W-1:0] index_gt_threshold;
    logic signed [BAND_W-1:0] index_lt_threshold_one;
    logic signed [BAND_W-1:0] index_lt_threshold_two;
    logic signed [BAND_W-1:0] nir_limit_one;
    logic signed [BAND_W-1:0] nir_limit_two;
    logic signed [BAND_W-1:0] swir_limit_one;
    logic signed [BAND_W-1:0] swir_limit_two;
  } swpc_cfg_t;

  // per-pixel flags that ride alongside the divider
  typedef struct packed {
    logic last;
    logic rule4;
    logic lim_one;
    logic lim_two;
    logic undef;
    logic neg;
  } swpc_meta_t;

  typedef struct packed {
    logic [SUM_W-1:0] num_mag;
    logic [SUM_W-1:0] den_mag;
    swpc_meta_t       meta;
  } swpc_div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             ovf;
    swpc_meta_t       meta;
  } swpc_div_out_t;

endpackage

[rtl/swpc_front.sv]
// front stages: band sums, limit and band-sum rules, magnitudes and sign of the index
module swpc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  swpc_pkg::swpc_in_t     in_data,
  input  swpc_pkg::swpc_cfg_t    cfg,
  output logic                   out_valid,
  output swpc_pkg::swpc_div_in_t out_data
);

  logic signed [swpc_pkg::SUM_W-1:0] g_ext, r_ext, n_ext, s_ext;
  logic signed [swpc_pkg::SUM_W-1:0] gr_sum, ns_sum;

  logic                              a_vld_r, a_vld_nxt;
  logic signed [swpc_pkg::SUM_W-1:0] a_num_r, a_num_nxt;
  logic signed [swpc_pkg::SUM_W-1:0] a_den_r, a_den_nxt;
  logic                              a_rule4_r, a_rule4_nxt;
  logic                              a_lim1_r, a_lim1_nxt;
  logic                              a_lim2_r, a_lim2_nxt;
  logic                              a_last_r, a_last_nxt;

  logic                   b_vld_r, b_vld_nxt;
  swpc_pkg::swpc_div_in_t b_data_r, b_data_nxt;
  logic [swpc_pkg::SUM_W-1:0] num_u, den_u;

  always_comb begin
    g_ext = $signed({in_data.green_band[swpc_pkg::BAND_W-1], in_data.green_band});
    r_ext = $signed({in_data.red_band[swpc_pkg::BAND_W-1], in_data.red_band});
    n_ext = $signed({in_data.nir_band[swpc_pkg::BAND_W-1], in_data.nir_band});
    s_ext = $signed({in_data.swir_band[swpc_pkg::BAND_W-1], in_data.swir_band});
    gr_sum = g_ext + r_ext;
    ns_sum = n_ext + s_ext;
    a_vld_nxt   = in_fire;
    a_num_nxt   = g_ext - s_ext;
    a_den_nxt   = g_ext + s_ext;
    a_rule4_nxt = gr_sum > ns_sum;
    a_lim1_nxt  = (in_data.nir_band <= cfg.nir_limit_one) &&
                  (in_data.swir_band <= cfg.swir_limit_one);
    a_lim2_nxt  = (in_data.nir_band <= cfg.nir_limit_two) &&
                  (in_data.swir_band <= cfg.swir_limit_two);
    a_last_nxt  = in_data.last_pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_num_r   <= a_num_nxt;
    a_den_r   <= a_den_nxt;
    a_rule4_r <= a_rule4_nxt;
    a_lim1_r  <= a_lim1_nxt;
    a_lim2_r  <= a_lim2_nxt;
    a_last_r  <= a_last_nxt;
  end

  always_comb begin
    num_u = a_num_r;
    den_u = a_den_r;
    b_vld_nxt = a_vld_r;
    b_data_nxt.num_mag = num_u[swpc_pkg::SUM_W-1] ? (~num_u + 1'b1) : num_u;
    b_data_nxt.den_mag = den_u[swpc_pkg::SUM_W-1] ? (~den_u + 1'b1) : den_u;
    b_data_nxt.meta.last    = a_last_r;
    b_data_nxt.meta.rule4   = a_rule4_r;
    b_data_nxt.meta.lim_one = a_lim1_r;
    b_data_nxt.meta.lim_two = a_lim2_r;
    // zero over zero leaves the index undefined
    b_data_nxt.meta.undef   = (num_u == '0) && (den_u == '0);
    // a zero denominator takes the sign of the numerator alone
    b_data_nxt.meta.neg     = num_u[swpc_pkg::SUM_W-1] ^ den_u[swpc_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_data_r <= b_data_nxt;
  end

  assign out_valid = b_vld_r;
  assign out_data  = b_data_r;

endmodule

[rtl/swpc_divider.sv]
// pipelined restoring divider on magnitudes, one quotient bit per stage, with overflow flag
module swpc_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  swpc_pkg::swpc_div_in_t  in_data,
  output logic                    out_valid,
  output swpc_pkg::swpc_div_out_t out_data
);

  localparam int QW = swpc_pkg::QUO_W;

  logic                          vld_r  [0:QW];
  logic [swpc_pkg::SUM_W-1:0]    rem_r  [0:QW];
  logic [swpc_pkg::SUM_W-1:0]    den_r  [0:QW];
  logic [QW-1:0]                 quo_r  [0:QW];
  logic                          ovf_r  [0:QW];
  swpc_pkg::swpc_meta_t          meta_r [0:QW];
  logic [QW-1:0]                 lo_r   [0:QW-1];

  logic [swpc_pkg::NA_W-1:0]  na;
  logic [swpc_pkg::HI_W-1:0]  hi_ext, den_ext;
  logic                       vld0_nxt, ovf0_nxt;
  logic [swpc_pkg::SUM_W-1:0] rem0_nxt;

  // quotient of 2^QW or more is an overflow; a zero divisor always lands here
  always_comb begin
    na       = {in_data.num_mag, {swpc_pkg::FRAC_BITS{1'b0}}};
    hi_ext   = swpc_pkg::HI_W'(na[swpc_pkg::NA_W-1:QW]);
    den_ext  = swpc_pkg::HI_W'(in_data.den_mag);
    ovf0_nxt = hi_ext >= den_ext;
    rem0_nxt = hi_ext[swpc_pkg::SUM_W-1:0];
    vld0_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem0_nxt;
    den_r[0]  <= in_data.den_mag;
    quo_r[0]  <= '0;
    ovf_r[0]  <= ovf0_nxt;
    meta_r[0] <= in_data.meta;
    lo_r[0]   <= na[QW-1:0];
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [swpc_pkg::REM_W-1:0] trial;
    logic [swpc_pkg::REM_W-1:0] diff;
    logic                       qbit;
    logic [swpc_pkg::SUM_W-1:0] rem_nxt;
    logic [QW-1:0]              quo_nxt;

    always_comb begin
      trial   = {rem_r[k-1], lo_r[k-1][QW-k]};
      diff    = trial - {1'b0, den_r[k-1]};
      qbit    = trial >= {1'b0, den_r[k-1]};
      rem_nxt = qbit ? diff[swpc_pkg::SUM_W-1:0] : trial[swpc_pkg::SUM_W-1:0];
      quo_nxt = {quo_r[k-1][QW-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_r[k-1];
      quo_r[k]  <= quo_nxt;
      ovf_r[k]  <= ovf_r[k-1];
      meta_r[k] <= meta_r[k-1];
    end

    if (k < QW) begin : g_lo
      always_ff @(posedge clk) begin
        lo_r[k] <= lo_r[k-1];
      end
    end
  end

  assign out_valid     = vld_r[QW];
  assign out_data.quo  = quo_r[QW];
  assign out_data.ovf  = ovf_r[QW];
  assign out_data.meta = meta_r[QW];

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[QW] && !ovf_r[QW]) |-> (rem_r[QW] < den_r[QW]))
    else $error("divider remainder not below divisor");

endmodule

[rtl/swpc_back.sv]
// back stages: sign and saturation of the index, threshold rules and the decimal code
module swpc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  swpc_pkg::swpc_div_out_t in_data,
  input  swpc_pkg::swpc_cfg_t     cfg,
  output logic                    out_strobe,
  output swpc_pkg::swpc_out_t     out_data
);

  localparam int QW = swpc_pkg::QUO_W;

  logic                             pos_sat, neg_sat;
  logic                             p_vld_r, p_vld_nxt;
  logic signed [swpc_pkg::IDX_W-1:0] p_idx_r, p_idx_nxt;
  swpc_pkg::swpc_meta_t             p_meta_r;

  logic                       r1, r2, r3;
  logic                       o_vld_r, o_vld_nxt;
  swpc_pkg::swpc_out_t        o_data_r, o_data_nxt;

  always_comb begin
    pos_sat   = in_data.ovf || in_data.quo[QW-1];
    // magnitude 2^(QW-1) still fits on the negative side
    neg_sat   = in_data.ovf || (in_data.quo[QW-1] && (|in_data.quo[QW-2:0]));
    p_vld_nxt = in_valid;
    if (in_data.meta.neg) begin
      p_idx_nxt = neg_sat ? swpc_pkg::IDX_MIN : swpc_pkg::IDX_W'(~in_data.quo + 1'b1);
    end else begin
      p_idx_nxt = pos_sat ? swpc_pkg::IDX_MAX : swpc_pkg::IDX_W'(in_data.quo);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r  <= p_idx_nxt;
    p_meta_r <= in_data.meta;
  end

  always_comb begin
    r1 = !p_meta_r.undef && (p_idx_r > cfg.index_gt_threshold);
    r2 = !p_meta_r.undef && (p_idx_r > cfg.index_lt_threshold_one) && p_meta_r.lim_one;
    r3 = !p_meta_r.undef && (p_idx_r > cfg.index_lt_threshold_two) && p_meta_r.lim_two;
    o_vld_nxt = p_vld_r;
    o_data_nxt.water_code = '0;
    if (r1) o_data_nxt.water_code = o_data_nxt.water_code + swpc_pkg::W_RULE1;
    if (r2) o_data_nxt.water_code = o_data_nxt.water_code + swpc_pkg::W_RULE2;
    if (r3) o_data_nxt.water_code = o_data_nxt.water_code + swpc_pkg::W_RULE3;
    if (p_meta_r.rule4) o_data_nxt.water_code = o_data_nxt.water_code + swpc_pkg::W_RULE4;
    o_data_nxt.last_pixel_out = p_meta_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_data_r <= o_data_nxt;
  end

  assign out_strobe = o_vld_r;
  assign out_data   = o_data_r;

  a_undef_no_index_rules: assert property (@(posedge clk) disable iff (!rst_n)
    (p_vld_r && p_meta_r.undef) |=>
      (out_strobe && (out_data.water_code == '0 || out_data.water_code == swpc_pkg::W_RULE4)))
    else $error("undefined index passed an index rule");

endmodule

[rtl/surface_water_pixel_classifier_top.sv]
// top level of the surface water pixel classifier: register port and pipeline
// One pixel can be started in every cycle (busy is always low) and its result appears on
// out_data with out_strobe high for exactly one cycle, after the front stages, the divider
// and the back stages; results leave in start order and the receiver cannot stall them.
// The pipeline runs through the divider for the wetness index, one quotient bit per stage
// over 16 stages plus an overflow stage, with two stages before it for band sums and
// magnitudes and two after it for saturation and the four rules. Registers sit at byte
// address 4*i; the user must write them only while no pixel is in flight, which the block
// itself does not enforce.
module surface_water_pixel_classifier_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  swpc_pkg::swpc_in_t             in_data,
  output logic                           out_strobe,
  output swpc_pkg::swpc_out_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [swpc_pkg::DATA_W-1:0]    pwdata,
  output logic [swpc_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  swpc_pkg::swpc_cfg_t cfg_r, cfg_nxt;
  logic [swpc_pkg::REG_IDX_W-1:0] reg_sel;
  logic [swpc_pkg::BAND_W-1:0]    wr_val;
  logic [swpc_pkg::BAND_W-1:0]    rd_val;
  logic                           cfg_write;
  logic                           in_fire;

  logic                    fr_valid;
  swpc_pkg::swpc_div_in_t  fr_data;
  logic                    dv_valid;
  swpc_pkg::swpc_div_out_t dv_data;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign in_fire   = start && !busy;
  assign reg_sel   = paddr[swpc_pkg::ADDR_W-1:2];
  assign wr_val    = pwdata[swpc_pkg::BAND_W-1:0];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (reg_sel)
        swpc_pkg::REG_INDEX_GT:     cfg_nxt.index_gt_threshold     = wr_val;
        swpc_pkg::REG_INDEX_LT_ONE: cfg_nxt.index_lt_threshold_one = wr_val;
        swpc_pkg::REG_INDEX_LT_TWO: cfg_nxt.index_lt_threshold_two = wr_val;
        swpc_pkg::REG_NIR_ONE:      cfg_nxt.nir_limit_one          = wr_val;
        swpc_pkg::REG_NIR_TWO:      cfg_nxt.nir_limit_two          = wr_val;
        swpc_pkg::REG_SWIR_ONE:     cfg_nxt.swir_limit_one         = wr_val;
        swpc_pkg::REG_SWIR_TWO:     cfg_nxt.swir_limit_two         = wr_val;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      swpc_pkg::REG_INDEX_GT:     rd_val = cfg_r.index_gt_threshold;
      swpc_pkg::REG_INDEX_LT_ONE: rd_val = cfg_r.index_lt_threshold_one;
      swpc_pkg::REG_INDEX_LT_TWO: rd_val = cfg_r.index_lt_threshold_two;
      swpc_pkg::REG_NIR_ONE:      rd_val = cfg_r.nir_limit_one;
      swpc_pkg::REG_NIR_TWO:      rd_val = cfg_r.nir_limit_two;
      swpc_pkg::REG_SWIR_ONE:     rd_val = cfg_r.swir_limit_one;
      swpc_pkg::REG_SWIR_TWO:     rd_val = cfg_r.swir_limit_two;
      default:                    rd_val = '0;
    endcase
    prdata = swpc_pkg::DATA_W'(rd_val);
  end

  swpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  swpc_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  swpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_data    (dv_data),
    .cfg        (cfg_r),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, swpc_pkg::PIPE_LAT))
    else $error("result strobe without a start transfer at the pipeline latency");

  a_last_follows_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.last_pixel_out == $past(in_data.last_pixel, swpc_pkg::PIPE_LAT)))
    else $error("last pixel flag lost its pixel");

endmodule

[tb/tb.sv]
// self-checking testbench for the surface water pixel classifier
`timescale 1ns / 100ps

module tb;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int NUM_PHASES     = 8;
  localparam int PIXELS_PER_SET = 205;
  localparam int CYCLE_LIMIT    = 200000;
  localparam logic [swpc_pkg::REG_IDX_W-1:0] REG_UNMAPPED = swpc_pkg::REG_IDX_W'(7);

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  swpc_pkg::swpc_in_t            in_data = '0;
  logic                          out_strobe;
  swpc_pkg::swpc_out_t           out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [swpc_pkg::ADDR_W-1:0]   paddr = '0;
  logic [swpc_pkg::DATA_W-1:0]   pwdata = '0;
  logic [swpc_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  swpc_pkg::swpc_in_t   pixel_q[$];
  swpc_pkg::swpc_out_t  water_code_q[$];
  logic [swpc_pkg::BAND_W-1:0] reg_shadow [swpc_pkg::NUM_REGS];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  int         gap_left = 0;
  bit         steady = 1'b0;

  surface_water_pixel_classifier_top dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic int shadow_val(input logic [swpc_pkg::REG_IDX_W-1:0] idx);
    return int'($signed(reg_shadow[idx]));
  endfunction

  function automatic swpc_pkg::swpc_out_t predict_water(input swpc_pkg::swpc_in_t px);
    int g, r, n, s, idx, code;
    longint num, den, quo;
    bit defined;
    swpc_pkg::swpc_out_t res;
    g = int'($signed(px.green_band));
    r = int'($signed(px.red_band));
    n = int'($signed(px.nir_band));
    s = int'($signed(px.swir_band));
    num = longint'(g) - longint'(s);
    den = longint'(g) + longint'(s);
    defined = 1'b1;
    idx = 0;
    if (den == 0) begin
      // 0/0 leaves the index undefined, otherwise it pins to an extreme
      if (num == 0) defined = 1'b0;
      else idx = (num > 0) ? int'($signed(swpc_pkg::IDX_MAX)) : int'($signed(swpc_pkg::IDX_MIN));
    end else begin
      quo = (num * (longint'(1) <<< swpc_pkg::FRAC_BITS)) / den;
      if (quo > longint'($signed(swpc_pkg::IDX_MAX))) quo = longint'($signed(swpc_pkg::IDX_MAX));
      if (quo < longint'($signed(swpc_pkg::IDX_MIN))) quo = longint'($signed(swpc_pkg::IDX_MIN));
      idx = int'(quo);
    end
    code = 0;
    if (defined && idx > shadow_val(swpc_pkg::REG_INDEX_GT)) code += swpc_pkg::W_RULE1;
    if (defined && idx > shadow_val(swpc_pkg::REG_INDEX_LT_ONE) &&
        n <= shadow_val(swpc_pkg::REG_NIR_ONE) &&
        s <= shadow_val(swpc_pkg::REG_SWIR_ONE)) code += swpc_pkg::W_RULE2;
    if (defined && idx > shadow_val(swpc_pkg::REG_INDEX_LT_TWO) &&
        n <= shadow_val(swpc_pkg::REG_NIR_TWO) &&
        s <= shadow_val(swpc_pkg::REG_SWIR_TWO)) code += swpc_pkg::W_RULE3;
    if (g + r > n + s) code += swpc_pkg::W_RULE4;
    res.water_code     = code[swpc_pkg::CODE_W-1:0];
    res.last_pixel_out = px.last_pixel;
    return res;
  endfunction

  function automatic swpc_pkg::swpc_in_t make_pixel(input int g, input int r, input int n,
                                                    input int s, input bit last);
    swpc_pkg::swpc_in_t px;
    px.green_band = swpc_pkg::BAND_W'(g);
    px.red_band   = swpc_pkg::BAND_W'(r);
    px.nir_band   = swpc_pkg::BAND_W'(n);
    px.swir_band  = swpc_pkg::BAND_W'(s);
    px.last_pixel = last;
    return px;
  endfunction

  function automatic int rand_band();
    int v;
    case ($urandom_range(0, 6))
      0, 1: v = int'($signed(16'($urandom)));
      2: v = int'($urandom_range(0, 128)) - 64;
      3: v = int'($urandom_range(0, 8000));
      4: v = -int'($urandom_range(0, 8000));
      5: v = int'($urandom_range(0, 4000)) - 1000;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic swpc_pkg::swpc_in_t rand_pixel();
    int g, s;
    g = rand_band();
    s = rand_band();
    // steer some pixels onto a zero denominator or a zero numerator
    case ($urandom_range(0, 9))
      0: s = -g;
      1: s = g;
      default: ;
    endcase
    return make_pixel(g, rand_band(), rand_band(), s, $urandom_range(0, 15) == 0);
  endfunction

  function automatic logic [swpc_pkg::BAND_W-1:0] rand_reg_value(input bit is_index);
    logic [swpc_pkg::BAND_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'($urandom);
      default: begin
        if (is_index) v = swpc_pkg::BAND_W'(int'($urandom_range(0, 32768)) - 16384);
        else v = swpc_pkg::BAND_W'(int'($urandom_range(0, 7000)) - 500);
      end
    endcase
    return v;
  endfunction

  task automatic write_reg(input logic [swpc_pkg::REG_IDX_W-1:0] idx,
                           input logic [swpc_pkg::BAND_W-1:0] val);
    logic [swpc_pkg::DATA_W-1:0] exp_rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < swpc_pkg::NUM_REGS) reg_shadow[idx] = val;
    // read back through the still selected address
    exp_rd = (idx < swpc_pkg::NUM_REGS) ? swpc_pkg::DATA_W'(val) : '0;
    @(negedge clk);
    if (prdata !== exp_rd)
      report_mismatch($sformatf("prdata got %0h exp %0h", prdata, exp_rd));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pixel_q.size() != 0 || start || water_code_q.size() != 0);
  endtask

  // stimulus driver: one transfer per accepted edge, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the offered pixel until it is taken
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pixel_q.size() != 0) begin
      if (!steady && $urandom_range(0, 9) == 0) begin
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 14);
      end else begin
        in_data <= pixel_q.pop_front();
        start   <= 1'b1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: checks results first, then predicts for the pixel taken at this edge
  always @(posedge clk) begin : monitor
    swpc_pkg::swpc_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (water_code_q.size() == 0) begin
          report_mismatch("result with no pixel pending");
        end else begin
          want = water_code_q.pop_front();
          if (out_data.water_code !== want.water_code)
            report_mismatch($sformatf("water_code got %0d exp %0d",
                                      out_data.water_code, want.water_code));
          if (out_data.last_pixel_out !== want.last_pixel_out)
            report_mismatch($sformatf("last_pixel_out got %0b exp %0b",
                                      out_data.last_pixel_out, want.last_pixel_out));
        end
      end
      if (start && !busy) water_code_q.push_back(predict_water(in_data));
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [swpc_pkg::BAND_W-1:0] val;
    for (int i = 0; i < swpc_pkg::NUM_REGS; i++) reg_shadow[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pixels under the reset thresholds
    pixel_q.push_back(make_pixel(0, 0, 0, 0, 1'b0));            // zero over zero
    pixel_q.push_back(make_pixel(5, 0, -3, -5, 1'b0));          // zero denominator, positive
    pixel_q.push_back(make_pixel(-5, 0, 0, 5, 1'b1));           // zero denominator, negative
    pixel_q.push_back(make_pixel(32767, 0, 0, -32768, 1'b0));   // huge negative quotient
    pixel_q.push_back(make_pixel(-32768, 0, 0, 32767, 1'b0));   // huge positive quotient
    pixel_q.push_back(make_pixel(32767, 32767, 32767, 32767, 1'b0));
    pixel_q.push_back(make_pixel(-32768, -32768, -32768, -32768, 1'b1));
    pixel_q.push_back(make_pixel(32767, -32768, -32768, 0, 1'b0));
    pixel_q.push_back(make_pixel(-32768, 32767, 0, 0, 1'b0));
    pixel_q.push_back(make_pixel(1, 0, 0, 0, 1'b0));
    pixel_q.push_back(make_pixel(0, 0, 0, 1, 1'b0));
    pixel_q.push_back(make_pixel(3, 0, 0, -1, 1'b0));           // exactly +2.0, saturates
    pixel_q.push_back(make_pixel(-3, 0, 0, 1, 1'b0));
    pixel_q.push_back(make_pixel(1, 0, 0, -3, 1'b0));           // exactly -2.0, fits
    pixel_q.push_back(make_pixel(32767, 32767, -32768, -32768, 1'b1));
    pixel_q.push_back(make_pixel(-32768, -32768, 32767, 32767, 1'b0));
    pixel_q.push_back(make_pixel(2000, 1500, -10, -100, 1'b0));
    pixel_q.push_back(make_pixel(2000, 1500, 1, -100, 1'b0));
    pixel_q.push_back(make_pixel(-32768, 0, 0, -32768, 1'b1));
    pixel_q.push_back(make_pixel(100, -100, 0, 0, 1'b0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        repeat (2) @(posedge clk);
        for (int i = 0; i < swpc_pkg::NUM_REGS; i++) begin
          case (ph)
            1: val = 16'h7FFF;
            2: val = 16'h8000;
            3: val = (i < 3) ? 16'h8000 : 16'h7FFF;
            default: val = rand_reg_value(i < 3);
          endcase
          write_reg(swpc_pkg::REG_IDX_W'(i), val);
        end
        if (ph == 3) write_reg(REG_UNMAPPED, 16'($urandom));
        @(negedge clk);
      end
      if (ph == NUM_PHASES - 1) steady = 1'b1;
      for (int k = 0; k < PIXELS_PER_SET; k++) pixel_q.push_back(rand_pixel());
    end

    wait_drained();
    repeat (swpc_pkg::PIPE_LAT + 8) @(posedge clk);
    if (water_code_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", water_code_q.size()));
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
